@@ sv/morse_code_translator_assert.svh @@
// Assertion macros shared by the translator's modules. Each macro expects
// signals named clk and rst in the scope where it is used.
`ifndef MORSE_CODE_TRANSLATOR_ASSERT_SVH
`define MORSE_CODE_TRANSLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mct_pkg.sv @@
package mct_pkg;

  // Direction of one input transaction.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_DOT    = 2'd0;
  localparam logic [1:0] KIND_DASH   = 2'd1;
  localparam logic [1:0] KIND_GAP    = 2'd2;
  localparam logic [1:0] KIND_LETTER = 2'd3;

  // ASCII characters the translator recognises.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam int unsigned NUM_LETTERS    = 26;
  localparam logic [2:0]  MAX_SYMBOLS    = 3'd4;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic       end_of_line;
  } char_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] letter;
    logic       last;
  } result_t;

  // One Morse code: symbol count and symbols, bit i is symbol i, 1 = dash.
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] bits;
  } code_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic       is_letter;
    code_t      code;
    logic [7:0] letter;
  } cmd_t;

  localparam code_t CODE_TABLE [NUM_LETTERS] = '{
    '{3'd2, 4'd2},  '{3'd4, 4'd1},  '{3'd4, 4'd5},  '{3'd3, 4'd1},
    '{3'd1, 4'd0},  '{3'd4, 4'd4},  '{3'd3, 4'd3},  '{3'd4, 4'd0},
    '{3'd2, 4'd0},  '{3'd4, 4'd14}, '{3'd3, 4'd5},  '{3'd4, 4'd2},
    '{3'd2, 4'd3},  '{3'd2, 4'd1},  '{3'd3, 4'd7},  '{3'd4, 4'd6},
    '{3'd4, 4'd11}, '{3'd3, 4'd2},  '{3'd3, 4'd0},  '{3'd1, 4'd1},
    '{3'd3, 4'd4},  '{3'd4, 4'd8},  '{3'd3, 4'd6},  '{3'd4, 4'd9},
    '{3'd4, 4'd13}, '{3'd4, 4'd3}
  };

  // Returns the uppercase letter whose code matches, or zero when none does.
  function automatic logic [7:0] lookup_letter(input code_t code);
    logic [7:0] found;
    found = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (CODE_TABLE[i] == code) begin
        found = CH_UPPER_A + 8'(i);
      end
    end
    return found;
  endfunction

endpackage

@@ sv/mct_front.sv @@
module mct_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mct_pkg::char_item_t item,
  output logic                cmd_valid,
  output mct_pkg::cmd_t       cmd
);
  import mct_pkg::*;

  logic [2:0] pending_length;
  logic [3:0] pending_symbols;
  logic       pending_too_long;
  logic [2:0] pending_length_next;
  logic [3:0] pending_symbols_next;
  logic       pending_too_long_next;

  logic       is_upper;
  logic       is_lower;
  logic [4:0] enc_index;
  code_t      upd_code;
  logic       upd_too_long;
  logic       is_symbol;
  logic       is_flush;
  logic [7:0] dec_letter;

  always_comb begin
    is_upper  = (item.char_code >= CH_UPPER_A) && (item.char_code <= CH_UPPER_Z);
    is_lower  = (item.char_code >= CH_LOWER_A) && (item.char_code <= CH_LOWER_Z);
    enc_index = is_lower ? 5'(item.char_code - CH_LOWER_A) : 5'(item.char_code - CH_UPPER_A);

    is_symbol    = (item.char_code == CH_DOT) || (item.char_code == CH_DASH);
    is_flush     = (item.char_code == CH_SPACE) || item.end_of_line;
    upd_code     = '{len: pending_length, bits: pending_symbols};
    upd_too_long = pending_too_long;
    if (is_symbol) begin
      if (pending_length < MAX_SYMBOLS) begin
        if (item.char_code == CH_DASH) begin
          upd_code.bits = pending_symbols | (4'b0001 << pending_length[1:0]);
        end
        upd_code.len = pending_length + 3'd1;
      end else begin
        upd_too_long = 1'b1;
      end
    end

    dec_letter = (upd_too_long || upd_code.len == 3'd0) ? 8'd0 : lookup_letter(upd_code);

    if (is_flush) begin
      pending_length_next   = '0;
      pending_symbols_next  = '0;
      pending_too_long_next = 1'b0;
    end else begin
      pending_length_next   = upd_code.len;
      pending_symbols_next  = upd_code.bits;
      pending_too_long_next = upd_too_long;
    end

    if (item.op == OP_ENCODE) begin
      cmd_valid = accept && (is_upper || is_lower);
      cmd       = '{is_letter: 1'b0, code: CODE_TABLE[enc_index], letter: 8'd0};
    end else begin
      cmd_valid = accept && is_flush && (dec_letter != 8'd0);
      cmd       = '{is_letter: 1'b1, code: '0, letter: dec_letter};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_length   <= '0;
      pending_symbols  <= '0;
      pending_too_long <= 1'b0;
    end else if (accept && item.op == OP_DECODE) begin
      pending_length   <= pending_length_next;
      pending_symbols  <= pending_symbols_next;
      pending_too_long <= pending_too_long_next;
    end
  end

endmodule

@@ sv/mct_fifo.sv @@
`include "morse_code_translator_assert.svh"

module mct_fifo #(
  parameter int unsigned DEPTH = mct_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mct_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output mct_pkg::cmd_t rdata
);
  import mct_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `MCT_ASSERT_SAME(a_fifo_bound, 1'b1, count <= CW'(DEPTH), "command queue overfilled")
  `MCT_ASSERT_NEXT(a_fifo_grow, push && !full && !pop, count == $past(count) + CW'(1), "command queue lost a write")

endmodule

@@ sv/mct_back.sv @@
`include "morse_code_translator_assert.svh"

module mct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_avail,
  input  mct_pkg::cmd_t    cmd,
  output logic             cmd_done,
  output logic             empty,
  input  logic             pop,
  output mct_pkg::result_t result
);
  import mct_pkg::*;

  logic       out_valid;
  result_t    out_data;
  logic [2:0] idx;
  logic       can_emit;
  logic       step;
  logic       is_final;
  result_t    result_next;

  always_comb begin
    can_emit = !out_valid || pop;
    step     = cmd_avail && can_emit;
    is_final = cmd.is_letter || (idx == cmd.code.len);

    if (cmd.is_letter) begin
      result_next = '{kind: KIND_LETTER, letter: cmd.letter, last: 1'b1};
    end else if (idx == cmd.code.len) begin
      result_next = '{kind: KIND_GAP, letter: 8'd0, last: 1'b1};
    end else begin
      result_next = '{kind: cmd.code.bits[idx[1:0]] ? KIND_DASH : KIND_DOT,
                      letter: 8'd0, last: 1'b0};
    end
  end

  assign cmd_done = step && is_final;
  assign empty    = !out_valid;
  assign result   = out_data;

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        idx       <= is_final ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MCT_ASSERT_SAME(a_back_idx, 1'b1, idx <= MAX_SYMBOLS, "symbol index ran past a full code")
  `MCT_ASSERT_SAME(a_back_letter_last, out_valid && out_data.kind == KIND_LETTER, out_data.last, "decoded letter not flagged last")

endmodule

@@ sv/morse_code_translator.sv @@
// Morse code translator for the letters A to Z, one ASCII character per input
// transaction. With op at encode, a letter of either case yields its dots and
// dashes, oldest symbol first, followed by a letter-gap result flagged last;
// any other character yields nothing. With op at decode, dots and dashes build
// a pending code of up to four symbols (a fifth spoils it); a space or the
// end-of-line flag looks the code up, yields the uppercase letter if it
// matches and clears the code, while other characters are ignored. Both sides
// behave as queues: push a transaction while full is low, and take a result
// with pop while empty is low. The result side delivers one result per cycle
// while pop is held and commands wait; an encoded letter yields its symbols
// plus the gap as results and a decoded letter yields one. The single result
// port of the back end sets the sustained rate, and FIFO_DEPTH commands may
// queue up ahead of it before full is raised. The first result reaches the
// result ports through the command queue and the registered output stage of
// the back end.
module morse_code_translator #(
  parameter int unsigned FIFO_DEPTH = mct_pkg::CMD_FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mct_pkg::char_item_t char_item,
  output logic                empty,
  input  logic                pop,
  output mct_pkg::result_t    result
);
  import mct_pkg::*;

  // Accepted input transaction; the front end classifies it in the same cycle.
  logic accept;

  // Command from the front end, and the head of the queue seen by the back end.
  logic cmd_valid;
  cmd_t cmd;
  logic head_avail;
  cmd_t head;
  logic head_done;
  logic queue_full;
  logic queue_empty;

  assign accept     = push && !queue_full;
  assign full       = queue_full;
  assign head_avail = !queue_empty;

  // The front end holds the pending decode state and turns each character into
  // at most one command: a code to play out, or a letter to deliver.
  mct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (char_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // The command queue lets the input side keep accepting while the back end is
  // still playing out an earlier letter or is held up by the consumer.
  mct_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (cmd),
    .full  (queue_full),
    .pop   (head_done),
    .empty (queue_empty),
    .rdata (head)
  );

  // The back end walks through the head command one result at a time into a
  // registered output stage, and releases the command with its final result.
  mct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (head_avail),
    .cmd       (head),
    .cmd_done  (head_done),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ sim/tb_morse_code_translator.sv @@
`timescale 1ns / 100ps

module tb_morse_code_translator;
  import mct_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_CHARS  = 250;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT_CHARS = 60;
  localparam int HOLD_CYCLES   = 160;
  localparam int IDLE_PERCENT  = 27;

  // The scoreboard keeps its own copy of the pending decode state and of the
  // Morse alphabet. Every accepted input transaction is turned into the
  // results it must cause, and every result taken from the block is checked
  // against the oldest of those.
  class morse_checker;
    result_t  expected_q[$];
    bit [2:0] held_len;
    bit [3:0] held_dashes;
    bit       held_spoilt;
    int       errors;
    int       chars_encoded;
    int       chars_decoded;
    int       letters_decoded;
    int       results_checked;

    function new();
      held_len    = '0;
      held_dashes = '0;
      held_spoilt = 1'b0;
      errors      = 0;
    endfunction

    // Dots and dashes of letter idx, A being zero, oldest symbol first.
    static function string letter_code(int idx);
      case (idx)
        0:  return ".-";
        1:  return "-...";
        2:  return "-.-.";
        3:  return "-..";
        4:  return ".";
        5:  return "..-.";
        6:  return "--.";
        7:  return "....";
        8:  return "..";
        9:  return ".---";
        10: return "-.-";
        11: return ".-..";
        12: return "--";
        13: return "-.";
        14: return "---";
        15: return ".--.";
        16: return "--.-";
        17: return ".-.";
        18: return "...";
        19: return "-";
        20: return "..-";
        21: return "...-";
        22: return ".--";
        23: return "-..-";
        24: return "-.--";
        default: return "--..";
      endcase
    endfunction

    function void note_char(char_item_t item);
      int         idx;
      string      code;
      result_t    res;
      bit [3:0]   dashes;
      logic [7:0] found;
      idx = -1;
      if (item.op == OP_ENCODE) begin
        if (item.char_code >= CH_UPPER_A && item.char_code <= CH_UPPER_Z) begin
          idx = int'(item.char_code - CH_UPPER_A);
        end else if (item.char_code >= CH_LOWER_A && item.char_code <= CH_LOWER_Z) begin
          idx = int'(item.char_code - CH_LOWER_A);
        end
        if (idx >= 0) begin
          chars_encoded++;
          code = letter_code(idx);
          for (int i = 0; i < code.len(); i++) begin
            res.kind   = (code[i] == CH_DASH) ? KIND_DASH : KIND_DOT;
            res.letter = '0;
            res.last   = 1'b0;
            expected_q.push_back(res);
          end
          res.kind   = KIND_GAP;
          res.letter = '0;
          res.last   = 1'b1;
          expected_q.push_back(res);
        end
        return;
      end

      chars_decoded++;
      if (item.char_code == CH_DOT || item.char_code == CH_DASH) begin
        if (held_len < 3'd4) begin
          if (item.char_code == CH_DASH) begin
            held_dashes[held_len[1:0]] = 1'b1;
          end
          held_len++;
        end else begin
          held_spoilt = 1'b1;
        end
      end

      if (item.char_code == CH_SPACE || item.end_of_line) begin
        found = '0;
        if (!held_spoilt && held_len != 0) begin
          for (int i = 0; i < 26; i++) begin
            code   = letter_code(i);
            dashes = '0;
            for (int j = 0; j < code.len(); j++) begin
              dashes[j] = (code[j] == CH_DASH);
            end
            if (code.len() == held_len && dashes == held_dashes) begin
              found = CH_UPPER_A + 8'(i);
            end
          end
        end
        held_len    = '0;
        held_dashes = '0;
        held_spoilt = 1'b0;
        if (found != 0) begin
          letters_decoded++;
          res.kind   = KIND_LETTER;
          res.letter = found;
          res.last   = 1'b1;
          expected_q.push_back(res);
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d letter %h last %0d", $time,
                 got.kind, got.letter, got.last);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch, expected kind %0d letter %h last %0d,",
                 $time, want.kind, want.letter, want.last,
                 " got kind %0d letter %h last %0d", got.kind, got.letter, got.last);
      end
    endfunction
  endclass

  logic       clk  = 1'b0;
  logic       rst  = 1'b1;
  logic       push = 1'b0;
  logic       pop  = 1'b0;
  char_item_t char_item = '0;
  logic       full;
  logic       empty;
  result_t    result;

  morse_checker sb = new();

  // When calm is set neither side idles, so the block runs at its full rate.
  bit calm = 1'b0;
  int chars_accepted = 0;
  int chars_offered = 0;
  int cycle_count = 0;

  morse_code_translator u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_item (char_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are observed on the clock edge itself. The inputs change
  // only through nonblocking assignments, so the values seen here are the
  // ones the block itself registered at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_char(char_item);
        chars_accepted++;
      end
      if (pop && !empty) begin
        sb.check_result(result);
      end
    end
  end

  // Watchdog: the slowest correct run is far below this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               sb.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. Once enough transactions have gone in, it stops taking results
  // for a long stretch, counted here, so that the command queue fills and
  // full stalls the sender. Otherwise it stalls at random, except while calm.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && chars_accepted >= HOLD_AT_CHARS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Offers one character and returns at the edge where it is accepted. Push
  // is left high, so a following transaction can go in straight away.
  task automatic offer_char(input logic op, input logic [7:0] ch, input logic eol);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push                  <= 1'b1;
    char_item.op          <= op;
    char_item.char_code   <= ch;
    char_item.end_of_line <= eol;
    do @(posedge clk); while (full);
    chars_offered++;
  endtask

  task automatic offer_text(input logic op, input string s, input bit eol_on_last);
    for (int i = 0; i < s.len(); i++) begin
      offer_char(op, s[i], eol_on_last && (i == s.len() - 1));
    end
  endtask

  // A character that decode mode ignores: anything but a dot, a dash or a space.
  function automatic logic [7:0] ignored_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == CH_DOT || ch == CH_DASH || ch == CH_SPACE) begin
      ch = CH_LOWER_A;
    end
    return ch;
  endfunction

  // A Morse word for a random letter, sometimes lengthened with extra symbols
  // that may spoil it, sometimes with noise between its symbols. It ends with a
  // space, with end_of_line on its last symbol, or with both together.
  task automatic offer_morse_word();
    string code;
    int    ending;
    int    extra;
    code   = morse_checker::letter_code($urandom_range(0, 25));
    ending = $urandom_range(0, 2);
    if ($urandom_range(0, 99) < 15) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) begin
        code = {code, ($urandom_range(0, 1) != 0) ? "-" : "."};
      end
    end
    for (int i = 0; i < code.len(); i++) begin
      if ($urandom_range(0, 99) < 10) begin
        // Encoding or an ignored character in the middle of a word must leave the word intact.
        if ($urandom_range(0, 1) != 0) begin
          offer_char(OP_ENCODE, CH_UPPER_A + 8'($urandom_range(0, 25)), 1'b0);
        end else begin
          offer_char(OP_DECODE, ignored_char(), 1'b0);
        end
      end
      offer_char(OP_DECODE, code[i], (ending == 1) && (i == code.len() - 1));
    end
    if (ending != 1) begin
      offer_char(OP_DECODE, CH_SPACE, ending == 2);
    end
  endtask

  initial begin : stimulus
    int         pick;
    int         directed;
    logic [7:0] ch;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Letters of both cases at the ends of the alphabet, then
    // the characters just outside each letter range, which must yield nothing.
    offer_text(OP_ENCODE, "Az", 1'b0);
    offer_char(OP_ENCODE, CH_UPPER_A - 8'd1, 1'b0);
    offer_char(OP_ENCODE, CH_UPPER_Z + 8'd1, 1'b0);
    offer_char(OP_ENCODE, CH_LOWER_A - 8'd1, 1'b1);
    offer_char(OP_ENCODE, CH_LOWER_Z + 8'd1, 1'b0);
    // A plain decode closed by a space, and F closed by end_of_line on its
    // final symbol.
    offer_text(OP_DECODE, ".- ", 1'b0);
    offer_text(OP_DECODE, "..-.", 1'b1);
    // Five symbols spoil the code; the flush is a space with end_of_line.
    offer_text(OP_DECODE, "----- ", 1'b1);
    // An encoded Q in the middle of a decode leaves the pending code alone.
    offer_char(OP_DECODE, CH_DASH, 1'b0);
    offer_char(OP_ENCODE, CH_UPPER_A + 8'd16, 1'b0);
    offer_text(OP_DECODE, "... ", 1'b0);
    // Four dashes match no letter.
    offer_text(OP_DECODE, "---- ", 1'b0);
    // Flush of an empty code through an otherwise ignored character.
    offer_char(OP_DECODE, CH_LOWER_A + 8'd16, 1'b1);
    directed = chars_offered;

    // Random part: mostly Morse words, otherwise encoded characters or noise.
    for (int n = 0; n < RANDOM_CHARS; n = chars_offered - directed) begin
      calm = (n >= 140 && n < 200);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        offer_morse_word();
      end else if (pick < 88) begin
        if ($urandom_range(0, 99) < 70) begin
          ch = (($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) +
               8'($urandom_range(0, 25));
        end else begin
          ch = 8'($urandom_range(0, 255));
        end
        offer_char(OP_ENCODE, ch, 1'($urandom_range(0, 1)));
      end else begin
        offer_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0);
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters: %0d letters encoded, %0d in decode mode, %0d letters decoded.",
             chars_accepted, sb.chars_encoded, sb.chars_decoded, sb.letters_decoded);
    $display("Checked %0d results, including a long receiver stall that filled the block.",
             sb.results_checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
